>>> hw/rtl/multichannel_biquad_df2t_assert.svh
// Assertion macros for the multichannel biquad block.
`ifndef MULTICHANNEL_BIQUAD_DF2T_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_DF2T_ASSERT_SVH

// Check a property, disabled while reset is high.
`define MBQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbq assertion failed");

// Check a property on every clock edge, reset included.
`define MBQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mbq assertion failed");

`endif

>>> hw/rtl/mbq_pkg.sv
package mbq_pkg;

   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int DELAY_W   = 56;
   localparam int FRAC_BITS = 24;
   localparam int ACC_W     = 58;
   localparam int T1_W      = 57;
   localparam int REG_IDX_W = 3;

   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DELAY_W-1:0]  delay_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_Y,
      ST_FB,
      ST_WB
   } state_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } reg_idx_type;

   localparam coef_type   COEF_B0_RESET = 32'sh0100_0000;
   localparam sample_type SAMPLE_MAX    = 24'sh7F_FFFF;
   localparam sample_type SAMPLE_MIN    = -24'sh80_0000;
   localparam delay_type  DELAY_MAX     = 56'sh7F_FFFF_FFFF_FFFF;
   localparam delay_type  DELAY_MIN     = -56'sh80_0000_0000_0000;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 58'sd8388608;

endpackage

>>> hw/rtl/multichannel_biquad_df2t.sv
// Multichannel biquad, direct form II transposed, one section shared by all channels.
// Input stream (req_): one sample per transaction, req_tdata = sample_in (24-bit signed),
// req_tuser = channel. Result stream (rsp_): rsp_tdata = sample_out (24-bit signed,
// saturated), rsp_tuser = {clipped, channel_out}.
// Coefficients b0, b1, b2, a1, a2 (signed Q8.24) are written through csr_we/csr_addr/
// csr_wdata at indexes 0 to 4; other indexes are ignored. Write them while idle.
// Sequence: an accepted sample passes the Y, FB and WB steps; its result enters rsp_ on
// leaving WB. req_tready stays low until idle again, so a new sample waits for the last.
// The steps come from the delay memory read and the two feedback multiplies that need y.
// A channel with no state (channel >= NUM_CHANNELS) passes its sample through unchanged.
// Receiver stall: the result waits in the output register; the next sample is still
// accepted and computed, then holds in the write-back step until the register frees.
// Reset (synchronous): coefficients return to b0 = 1.0 and the rest zero, every channel's
// delay words read as zero (valid bits cleared at once), both streams go empty.
module multichannel_biquad_df2t #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_in
   input  logic [2:0]  req_tuser,   // [2:0] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] sample_out
   output logic [3:0]  rsp_tuser,   // [2:0] channel_out, [3] clipped
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CW      = (AW > mbq_pkg::CHAN_W) ? AW : mbq_pkg::CHAN_W;
   localparam int ACC_W   = mbq_pkg::ACC_W;
   localparam int T1_W    = mbq_pkg::T1_W;
   localparam int DELAY_W = mbq_pkg::DELAY_W;
   localparam int YW      = mbq_pkg::ACC_W - mbq_pkg::FRAC_BITS;

   mbq_pkg::state_type state_ff, state_in;

   mbq_pkg::coef_type b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   logic [2*DELAY_W-1:0] delay_mem [NUM_CHANNELS];
   logic [2*DELAY_W-1:0] delay_rd_ff;
   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;
   logic rdv_ff;

   logic [CW:0]   ch_ext;
   logic [AW-1:0] rd_addr;
   logic          present_in;
   logic          accept;
   logic          advance;
   logic          mem_we;

   logic [mbq_pkg::CHAN_W-1:0] chan_ff;
   logic [AW-1:0]              addr_ff;
   logic                       present_ff;
   mbq_pkg::sample_type        x_ff, x_in;

   mbq_pkg::coef_type   ma_coef, mb_coef;
   mbq_pkg::sample_type ma_op, mb_op;
   mbq_pkg::delay_type  prod_a, prod_b;
   mbq_pkg::delay_type  pa_ff, pa_in, pb_ff, pb_in;

   mbq_pkg::delay_type       s1_cur, s2_cur;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [YW-1:0]     y_wide;
   mbq_pkg::sample_type      y_ff, y_in;
   logic                     clip_ff, clip_in;
   logic signed [T1_W-1:0]   t1_ff, t1_in;
   mbq_pkg::delay_type       t2_ff, t2_in;

   logic signed [ACC_W-1:0]  s1_full;
   logic signed [T1_W-1:0]   s2_full;
   mbq_pkg::delay_type       s1_new, s2_new;

   logic                     rsp_valid_ff, rsp_valid_in;
   mbq_pkg::sample_type      rsp_data_ff, rsp_data_in;
   logic [mbq_pkg::CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic                     rsp_clip_ff, rsp_clip_in;

   assign ch_ext     = (CW+1)'(req_tuser);
   assign present_in = ch_ext < (CW+1)'(NUM_CHANNELS);
   assign rd_addr    = ch_ext[AW-1:0];
   assign x_in       = req_tdata;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= mbq_pkg::COEF_B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            mbq_pkg::REG_B0: b0_ff <= csr_wdata;
            mbq_pkg::REG_B1: b1_ff <= csr_wdata;
            mbq_pkg::REG_B2: b2_ff <= csr_wdata;
            mbq_pkg::REG_A1: a1_ff <= csr_wdata;
            mbq_pkg::REG_A2: a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      advance    = 1'b0;
      case (state_ff)
         mbq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (req_tvalid) begin
               state_in = mbq_pkg::ST_Y;
            end
         end
         mbq_pkg::ST_Y: begin
            state_in = mbq_pkg::ST_FB;
         end
         mbq_pkg::ST_FB: begin
            state_in = mbq_pkg::ST_WB;
         end
         mbq_pkg::ST_WB: begin
            advance = !rsp_valid_ff || rsp_tready;
            if (advance) begin
               state_in = mbq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbq_pkg::ST_IDLE;
         end
      endcase
   end

   // shared multipliers: coef * x first, coef * y once y is known
   always_comb begin
      case (state_ff)
         mbq_pkg::ST_IDLE: begin
            ma_coef = b0_ff;
            ma_op   = x_in;
            mb_coef = b1_ff;
            mb_op   = x_in;
         end
         mbq_pkg::ST_Y: begin
            ma_coef = b2_ff;
            ma_op   = x_ff;
            mb_coef = b1_ff;
            mb_op   = x_ff;
         end
         default: begin
            ma_coef = a1_ff;
            ma_op   = y_ff;
            mb_coef = a2_ff;
            mb_op   = y_ff;
         end
      endcase
   end

   assign prod_a = ma_coef * ma_op;
   assign prod_b = mb_coef * mb_op;

   assign s1_cur  = rdv_ff ? delay_rd_ff[DELAY_W-1:0] : '0;
   assign s2_cur  = rdv_ff ? delay_rd_ff[2*DELAY_W-1:DELAY_W] : '0;
   assign acc_rnd = ACC_W'(pa_ff) + ACC_W'(s1_cur) + mbq_pkg::ROUND_HALF;
   assign y_wide  = acc_rnd[ACC_W-1:mbq_pkg::FRAC_BITS];

   assign s1_full = ACC_W'(t1_ff) - ACC_W'(pa_ff);
   assign s2_full = T1_W'(t2_ff) - T1_W'(pb_ff);

   always_comb begin
      pa_in   = (state_ff == mbq_pkg::ST_WB) ? pa_ff : prod_a;
      pb_in   = (state_ff == mbq_pkg::ST_WB) ? pb_ff : prod_b;
      y_in    = y_ff;
      clip_in = clip_ff;
      t1_in   = t1_ff;
      t2_in   = t2_ff;

      if (state_ff == mbq_pkg::ST_Y) begin
         t1_in = T1_W'(pb_ff) + T1_W'(s2_cur);
         if (y_wide > YW'(mbq_pkg::SAMPLE_MAX)) begin
            y_in    = mbq_pkg::SAMPLE_MAX;
            clip_in = 1'b1;
         end else if (y_wide < YW'(mbq_pkg::SAMPLE_MIN)) begin
            y_in    = mbq_pkg::SAMPLE_MIN;
            clip_in = 1'b1;
         end else begin
            y_in    = y_wide[mbq_pkg::SAMPLE_W-1:0];
            clip_in = 1'b0;
         end
      end
      if (state_ff == mbq_pkg::ST_FB) begin
         t2_in = pa_ff;
      end

      if (s1_full > ACC_W'(mbq_pkg::DELAY_MAX)) begin
         s1_new = mbq_pkg::DELAY_MAX;
      end else if (s1_full < ACC_W'(mbq_pkg::DELAY_MIN)) begin
         s1_new = mbq_pkg::DELAY_MIN;
      end else begin
         s1_new = s1_full[DELAY_W-1:0];
      end
      if (s2_full > T1_W'(mbq_pkg::DELAY_MAX)) begin
         s2_new = mbq_pkg::DELAY_MAX;
      end else if (s2_full < T1_W'(mbq_pkg::DELAY_MIN)) begin
         s2_new = mbq_pkg::DELAY_MIN;
      end else begin
         s2_new = s2_full[DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      y_ff    <= y_in;
      clip_ff <= clip_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      if (accept) begin
         x_ff       <= x_in;
         chan_ff    <= req_tuser;
         addr_ff    <= rd_addr;
         present_ff <= present_in;
      end
   end

   // delay memory: read on accept, write back on leaving the write-back step
   assign mem_we = advance && present_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[addr_ff] <= {s2_new, s1_new};
      end
      if (accept) begin
         delay_rd_ff <= delay_mem[rd_addr];
         rdv_ff      <= present_in && valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_clip_in  = rsp_clip_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = present_ff ? y_ff : x_ff;
         rsp_chan_in  = chan_ff;
         rsp_clip_in  = present_ff && clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = {rsp_clip_ff, rsp_chan_ff};

endmodule

>>> hw/rtl/mbq_checker.sv
`include "multichannel_biquad_df2t_assert.svh"

module mbq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   `MBQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `MBQ_ASSERT(a_busy_after_accept, clock, reset, req_tvalid && req_tready |=> !req_tready ##1 !req_tready ##1 !req_tready)
   `MBQ_ASSERT(a_clip_saturates, clock, reset, rsp_tvalid && rsp_tuser[3] |-> rsp_tdata == 24'h7FFFFF || rsp_tdata == 24'h800000)
   `MBQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind multichannel_biquad_df2t mbq_checker u_mbq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
